### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

### hw/rtl/regalu_pkg.sv
package regalu_pkg;

    typedef enum logic [2:0] {
        OP_CMOV   = 3'd0,
        OP_ADD    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_NAND   = 3'd4,
        OP_LOADI  = 3'd5,
        OP_OUTPUT = 3'd6,
        OP_INPUT  = 3'd7
    } op_t;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO  = 2'd1;
    localparam logic [1:0] ERR_OUT_RANGE = 2'd2;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned NUM_REG = 8;

    // decoded item as it travels from the front end to the execute side
    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   dest;
        logic [IDX_W-1:0]   src_b;
        logic [IDX_W-1:0]   src_c;
        logic [WORD_W-1:0]  value;
    } item_t;

endpackage

### hw/rtl/regalu_chan_if.sv
interface regalu_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [2:0]  reg_a;
    logic [2:0]  reg_b;
    logic [2:0]  reg_c;
    logic [31:0] immediate;
    logic [7:0]  char_in;
    logic        at_eof;

    modport source (
        output valid, command, reg_a, reg_b, reg_c, immediate, char_in, at_eof,
        input  ready
    );
    modport sink (
        input  valid, command, reg_a, reg_b, reg_c, immediate, char_in, at_eof,
        output ready
    );
endinterface

interface regalu_out_if;
    logic        valid;
    logic        ready;
    logic        char_valid;
    logic [7:0]  char_out;
    logic [1:0]  error_code;

    modport source (
        output valid, char_valid, char_out, error_code,
        input  ready
    );
    modport sink (
        input  valid, char_valid, char_out, error_code,
        output ready
    );
endinterface

### hw/rtl/regalu_front.sv
module regalu_front (
    regalu_in_if.sink           req,
    output logic                push_valid,
    output regalu_pkg::item_t   push_item,
    input  logic                push_ready
);
    import regalu_pkg::*;

    op_t op;

    assign op         = op_t'(req.command);
    assign push_valid = req.valid;
    assign req.ready  = push_ready;

    always_comb
    begin
        push_item.op    = op;
        push_item.src_b = req.reg_b;
        push_item.src_c = req.reg_c;
        push_item.dest  = req.reg_a;
        push_item.value = req.immediate;
        unique case (op)
            OP_INPUT:
            begin
                // input writes register c
                push_item.dest  = req.reg_c;
                push_item.value = req.at_eof ? {WORD_W{1'b1}}
                                             : {{(WORD_W-CHAR_W){1'b0}}, req.char_in};
            end
            OP_LOADI:
            begin
                push_item.value = req.immediate;
            end
            OP_CMOV, OP_ADD, OP_MUL, OP_DIV, OP_NAND, OP_OUTPUT:
            begin
                push_item.value = '0;
            end
        endcase
    end

endmodule

### hw/rtl/regalu_queue.sv
module regalu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  regalu_pkg::item_t   push_item,
    output logic                push_ready,
    output logic                pop_valid,
    output regalu_pkg::item_t   pop_item,
    input  logic                pop_ready
);
    import regalu_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    logic        pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/regalu_div.sv
module regalu_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [31:0]  dividend,
    input  logic [31:0]  divisor,
    output logic         done,
    output logic [31:0]  quotient
);
    import regalu_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    // one quotient bit per cycle, restoring
    assign trial    = {rem_reg, quo_reg[WORD_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], ~diff[WORD_W]};
        end
    end

endmodule

### hw/rtl/regalu_back.sv
module regalu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  regalu_pkg::item_t   pop_item,
    output logic                pop_ready,
    regalu_out_if.source        rsp
);
    import regalu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    item_t              item_reg;
    logic [WORD_W-1:0]  rf_reg [NUM_REG];
    logic [NUM_REG-1:0] rf_vld_reg;
    logic [WORD_W-1:0]  rd_b_reg;
    logic [WORD_W-1:0]  rd_c_reg;
    logic               rdv_b_reg;
    logic               rdv_c_reg;
    logic [WORD_W-1:0]  prod_reg;
    logic               char_valid_reg;
    logic               char_valid_next;
    logic [CHAR_W-1:0]  char_out_reg;
    logic [CHAR_W-1:0]  char_out_next;
    logic [1:0]         err_reg;
    logic [1:0]         err_next;
    logic [WORD_W-1:0]  vb;
    logic [WORD_W-1:0]  vc;
    logic               vc_zero;
    logic               wr_en;
    logic [WORD_W-1:0]  wr_data;
    logic               div_start;
    logic               div_done;
    logic [WORD_W-1:0]  div_quo;

    // a register never written since reset reads as zero
    assign vb      = rdv_b_reg ? rd_b_reg : '0;
    assign vc      = rdv_c_reg ? rd_c_reg : '0;
    assign vc_zero = (vc == '0);

    assign pop_ready      = (state_reg == S_IDLE);
    assign rsp.valid      = (state_reg == S_OUT);
    assign rsp.char_valid = char_valid_reg;
    assign rsp.char_out   = char_out_reg;
    assign rsp.error_code = err_reg;

    assign div_start = (state_reg == S_EXEC) && (item_reg.op == OP_DIV) && !vc_zero;

    regalu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vb),
        .divisor  (vc),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next      = state_reg;
        wr_en           = 1'b0;
        wr_data         = '0;
        char_valid_next = char_valid_reg;
        char_out_next   = char_out_reg;
        err_next        = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                char_valid_next = 1'b0;
                char_out_next   = '0;
                err_next        = ERR_NONE;
                state_next      = S_OUT;
                unique case (item_reg.op)
                    OP_CMOV:
                    begin
                        wr_en   = !vc_zero;
                        wr_data = vb;
                    end
                    OP_ADD:
                    begin
                        wr_en   = 1'b1;
                        wr_data = vb + vc;
                    end
                    OP_MUL:
                    begin
                        state_next = S_MUL;
                    end
                    OP_DIV:
                    begin
                        if (vc_zero)
                        begin
                            err_next = ERR_DIV_ZERO;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                    OP_NAND:
                    begin
                        wr_en   = 1'b1;
                        wr_data = ~(vb & vc);
                    end
                    OP_LOADI, OP_INPUT:
                    begin
                        wr_en   = 1'b1;
                        wr_data = item_reg.value;
                    end
                    OP_OUTPUT:
                    begin
                        if (vc[WORD_W-1:CHAR_W] != '0)
                        begin
                            err_next = ERR_OUT_RANGE;
                        end
                        else
                        begin
                            char_valid_next = 1'b1;
                            char_out_next   = vc[CHAR_W-1:0];
                        end
                    end
                endcase
            end
            S_MUL:
            begin
                wr_en      = 1'b1;
                wr_data    = prod_reg;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = div_quo;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rf_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                rf_vld_reg[item_reg.dest] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_b_reg       <= rf_reg[pop_item.src_b];
        rd_c_reg       <= rf_reg[pop_item.src_c];
        rdv_b_reg      <= rf_vld_reg[pop_item.src_b];
        rdv_c_reg      <= rf_vld_reg[pop_item.src_c];
        prod_reg       <= vb * vc;
        char_valid_reg <= char_valid_next;
        char_out_reg   <= char_out_next;
        err_reg        <= err_next;
        if (pop_valid && pop_ready)
        begin
            item_reg <= pop_item;
        end
        if (wr_en)
        begin
            rf_reg[item_reg.dest] <= wr_data;
        end
    end

endmodule

### hw/rtl/um_register_alu_unit.sv
// register unit: eight 32-bit registers worked on by one instruction per item
// req channel: command, reg_a, reg_b, reg_c, immediate, char_in, at_eof
// rsp channel: char_valid, char_out, error_code, exactly one item per req item
// both channels move an item when valid and ready are high at a rising clk
// the front end decodes each item into a two-entry queue and stays ready
// while that queue has room, so it keeps taking items while a result waits
// the back end runs one item at a time out of the queue:
//   cmov, add, nand, load immediate, output, input: S_EXEC, then S_OUT (rsp valid)
//   mul: S_EXEC, S_MUL, then S_OUT; the product is registered before the write
//   div: S_EXEC, then S_DIV until the radix-2 divider is done, one quotient bit a cycle
// plus the return to S_IDLE after rsp is taken, before the next queue read
// a fault (divide by zero, output value of 256 or more) leaves the registers
// untouched and only sets error_code
// a stalled rsp holds its item, and the queue fills before req.ready drops
// reset (rst_n low, asynchronous) makes all registers read as zero, empties the
// queue and drops rsp.valid
module um_register_alu_unit (
    input  logic          clk,
    input  logic          rst_n,
    regalu_in_if.sink     req,
    regalu_out_if.source  rsp
);
    import regalu_pkg::*;

    logic   push_valid;
    logic   push_ready;
    item_t  push_item;
    logic   pop_valid;
    logic   pop_ready;
    item_t  pop_item;

    regalu_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    regalu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    regalu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .rsp       (rsp)
    );

endmodule

### hw/rtl/regalu_check.sv
`include "assert_macros.svh"

module regalu_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic        char_valid,
    input  logic [7:0]  char_out,
    input  logic [1:0]  error_code
);
    import regalu_pkg::*;

    `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(char_valid) && $stable(char_out) && $stable(error_code))
    `CHK_IMPLY(a_char_no_err, rsp_valid && char_valid, error_code == ERR_NONE)
    `CHK_IMPLY(a_no_char_zero, rsp_valid && !char_valid, char_out == 8'd0)
    `CHK_IMPLY(a_reset_quiet, $rose(rst_n), !rsp_valid)

endmodule

bind um_register_alu_unit regalu_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .char_valid (rsp.char_valid),
    .char_out   (rsp.char_out),
    .error_code (rsp.error_code)
);

### test/um_register_alu_unit_test.sv
module um_register_alu_unit_test;
    import regalu_pkg::*;

    typedef struct packed {
        op_t         cmd;
        logic [2:0]  a;
        logic [2:0]  b;
        logic [2:0]  c;
        logic [31:0] imm;
        logic [7:0]  ch;
        logic        eof;
    } instr_t;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  char_out;
        logic [1:0]  error_code;
    } result_t;

    typedef struct packed {
        instr_t      instr;
        logic        fixed;
        result_t     res;
    } row_t;

    localparam int RANDOM_ITEMS = 1250;
    localparam int NUM_ROWS = 25;

    logic clk;
    logic rst_n;

    regalu_in_if  req_if ();
    regalu_out_if rsp_if ();

    um_register_alu_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    logic [31:0] model_regs [NUM_REG];
    result_t     pending_results [$];
    int          error_count;
    row_t        directed_rows [NUM_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic result_t step_registers(input instr_t s);
        result_t     r;
        logic [31:0] vb;
        logic [31:0] vc;
        vb = model_regs[s.b];
        vc = model_regs[s.c];
        r = '0;
        r.error_code = ERR_NONE;
        case (s.cmd)
            OP_CMOV:
            begin
                if (vc != 32'd0)
                    model_regs[s.a] = vb;
            end
            OP_ADD:  model_regs[s.a] = vb + vc;
            OP_MUL:  model_regs[s.a] = vb * vc;
            OP_DIV:
            begin
                if (vc == 32'd0)
                    r.error_code = ERR_DIV_ZERO;
                else
                    model_regs[s.a] = vb / vc;
            end
            OP_NAND: model_regs[s.a] = ~(vb & vc);
            OP_LOADI: model_regs[s.a] = s.imm;
            OP_OUTPUT:
            begin
                if (vc >= 32'd256)
                    r.error_code = ERR_OUT_RANGE;
                else
                begin
                    r.char_valid = 1'b1;
                    r.char_out = vc[7:0];
                end
            end
            default: model_regs[s.c] = s.eof ? 32'hFFFF_FFFF : {24'd0, s.ch};
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input instr_t s, input logic fixed, input result_t fixed_res);
        result_t want;
        int      gap;
        @(negedge clk);
        req_if.valid     <= 1'b1;
        req_if.command   <= s.cmd;
        req_if.reg_a     <= s.a;
        req_if.reg_b     <= s.b;
        req_if.reg_c     <= s.c;
        req_if.immediate <= s.imm;
        req_if.char_in   <= s.ch;
        req_if.at_eof    <= s.eof;
        do
            @(posedge clk);
        while (!req_if.ready);
        want = step_registers(s);
        pending_results.push_back(fixed ? fixed_res : want);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic instr_t random_instr();
        instr_t s;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 10)
            s.cmd = OP_CMOV;
        else if (r < 20)
            s.cmd = OP_ADD;
        else if (r < 30)
            s.cmd = OP_MUL;
        else if (r < 38)
            s.cmd = OP_DIV;
        else if (r < 46)
            s.cmd = OP_NAND;
        else if (r < 62)
            s.cmd = OP_LOADI;
        else if (r < 82)
            s.cmd = OP_OUTPUT;
        else
            s.cmd = OP_INPUT;
        s.a = 3'($urandom_range(0, 7));
        s.b = 3'($urandom_range(0, 7));
        s.c = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
            0: s.imm = $urandom_range(0, 255);
            1: s.imm = 32'd0;
            2: s.imm = 32'hFFFF_FFFF;
            3: s.imm = $urandom_range(250, 260);
            default: s.imm = $urandom;
        endcase
        s.ch = 8'($urandom_range(0, 255));
        s.eof = ($urandom_range(0, 7) == 0);
        return s;
    endfunction

    // response side backpressure
    initial
    begin : rsp_ready_gen
        int hold;
        hold = 0;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (rsp_if.ready)
            begin
                rsp_if.ready <= 1'b0;
                hold = pick_gap();
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                hold = $urandom_range(1, 25);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result item with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.char_valid !== want.char_valid)
                    report_mismatch($sformatf("char_valid %b, expected %b",
                        rsp_if.char_valid, want.char_valid));
                if (rsp_if.char_out !== want.char_out)
                    report_mismatch($sformatf("char_out %h, expected %h",
                        rsp_if.char_out, want.char_out));
                if (rsp_if.error_code !== want.error_code)
                    report_mismatch($sformatf("error_code %0d, expected %0d",
                        rsp_if.error_code, want.error_code));
            end
        end
    end

    initial
    begin
        int i;
        error_count = 0;
        rst_n = 1'b0;
        req_if.valid <= 1'b0;
        req_if.command <= OP_CMOV;
        req_if.reg_a <= '0;
        req_if.reg_b <= '0;
        req_if.reg_c <= '0;
        req_if.immediate <= '0;
        req_if.char_in <= '0;
        req_if.at_eof <= 1'b0;
        for (i = 0; i < NUM_REG; i++)
            model_regs[i[2:0]] = 32'd0;

        // instruction, fixed expectation flag, fixed expectation
        directed_rows = '{
            '{'{OP_OUTPUT, 3'd0, 3'd0, 3'd0, 32'd0, 8'd0, 1'b0}, 1'b1, '{1'b1, 8'd0, ERR_NONE}},
            '{'{OP_DIV, 3'd1, 3'd2, 3'd0, 32'd0, 8'd0, 1'b0}, 1'b1, '{1'b0, 8'd0, ERR_DIV_ZERO}},
            '{'{OP_LOADI, 3'd1, 3'd0, 3'd0, 32'hFFFF_FFFF, 8'd0, 1'b0}, 1'b1,
                '{1'b0, 8'd0, ERR_NONE}},
            '{'{OP_OUTPUT, 3'd0, 3'd0, 3'd1, 32'd0, 8'd0, 1'b0}, 1'b1,
                '{1'b0, 8'd0, ERR_OUT_RANGE}},
            '{'{OP_LOADI, 3'd2, 3'd0, 3'd0, 32'd255, 8'd0, 1'b0}, 1'b1, '{1'b0, 8'd0, ERR_NONE}},
            '{'{OP_OUTPUT, 3'd0, 3'd0, 3'd2, 32'd0, 8'd0, 1'b0}, 1'b1, '{1'b1, 8'hFF, ERR_NONE}},
            '{'{OP_LOADI, 3'd3, 3'd0, 3'd0, 32'd256, 8'd0, 1'b0}, 1'b1, '{1'b0, 8'd0, ERR_NONE}},
            '{'{OP_OUTPUT, 3'd0, 3'd0, 3'd3, 32'd0, 8'd0, 1'b0}, 1'b1,
                '{1'b0, 8'd0, ERR_OUT_RANGE}},
            '{'{OP_ADD, 3'd4, 3'd1, 3'd1, 32'd0, 8'd0, 1'b0}, 1'b0, '0},
            '{'{OP_MUL, 3'd5, 3'd1, 3'd1, 32'd0, 8'd0, 1'b0}, 1'b0, '0},
            '{'{OP_DIV, 3'd6, 3'd1, 3'd2, 32'd0, 8'd0, 1'b0}, 1'b0, '0},
            '{'{OP_NAND, 3'd7, 3'd1, 3'd1, 32'd0, 8'd0, 1'b0}, 1'b0, '0},
            '{'{OP_CMOV, 3'd0, 3'd1, 3'd7, 32'd0, 8'd0, 1'b0}, 1'b0, '0},
            '{'{OP_OUTPUT, 3'd0, 3'd0, 3'd0, 32'd0, 8'd0, 1'b0}, 1'b1, '{1'b1, 8'd0, ERR_NONE}},
            '{'{OP_CMOV, 3'd0, 3'd1, 3'd2, 32'd0, 8'd0, 1'b0}, 1'b0, '0},
            '{'{OP_OUTPUT, 3'd0, 3'd0, 3'd0, 32'd0, 8'd0, 1'b0}, 1'b1,
                '{1'b0, 8'd0, ERR_OUT_RANGE}},
            '{'{OP_INPUT, 3'd0, 3'd0, 3'd3, 32'd0, 8'h41, 1'b0}, 1'b0, '0},
            '{'{OP_OUTPUT, 3'd0, 3'd0, 3'd3, 32'd0, 8'd0, 1'b0}, 1'b1, '{1'b1, 8'h41, ERR_NONE}},
            '{'{OP_INPUT, 3'd0, 3'd0, 3'd3, 32'd0, 8'h55, 1'b1}, 1'b0, '0},
            '{'{OP_OUTPUT, 3'd0, 3'd0, 3'd3, 32'd0, 8'd0, 1'b0}, 1'b1,
                '{1'b0, 8'd0, ERR_OUT_RANGE}},
            '{'{OP_INPUT, 3'd0, 3'd0, 3'd4, 32'd0, 8'hFF, 1'b0}, 1'b0, '0},
            '{'{OP_OUTPUT, 3'd0, 3'd0, 3'd4, 32'd0, 8'd0, 1'b0}, 1'b1, '{1'b1, 8'hFF, ERR_NONE}},
            '{'{OP_DIV, 3'd5, 3'd1, 3'd7, 32'd0, 8'd0, 1'b0}, 1'b1, '{1'b0, 8'd0, ERR_DIV_ZERO}},
            '{'{OP_DIV, 3'd6, 3'd2, 3'd6, 32'd0, 8'd0, 1'b0}, 1'b0, '0},
            '{'{OP_ADD, 3'd0, 3'd4, 3'd2, 32'd0, 8'd0, 1'b0}, 1'b0, '0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < NUM_ROWS; i++)
            send_item(directed_rows[i[4:0]].instr, directed_rows[i[4:0]].fixed,
                directed_rows[i[4:0]].res);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // let the unit drain completely once mid-run
            if (i == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                req_if.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                repeat (5) @(negedge clk);
            end
            send_item(random_instr(), 1'b0, '0);
        end

        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
